>>> rtl/fama_pkg.sv
// shared types, constants and helper functions for the framed ascii moving average
package fama_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_START_TAG   = 3'd0;
  localparam logic [2:0] CFG_STOP_TAG    = 3'd1;
  localparam logic [2:0] CFG_SCALE_RECIP = 3'd2;
  localparam logic [2:0] CFG_PLAIN_LEN   = 3'd3;
  localparam logic [2:0] CFG_WEIGHT_LEN  = 3'd4;
  localparam logic [2:0] CFG_WEIGHT_TAB  = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // default parameter values
  localparam int PLAIN_DEPTH_DEF  = 16;
  localparam int WEIGHT_DEPTH_DEF = 4;
  localparam int FRAC_BITS_DEF    = 16;

  // digit accumulator
  localparam int ACC_W = 48;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // widths of the back end datapath
  localparam int PROD_W  = 80;  // accumulator times reciprocal
  localparam int DIV_NW  = 88;  // dividend, room for the largest left shift
  localparam int DIV_DW  = 50;  // divisor, holds 10^15
  localparam int DIV_QW  = 33;  // kept quotient bits
  localparam int DIV_CW  = 7;   // step counter
  localparam int PSUM_W  = 40;  // plain window sum
  localparam int PCNT_W  = 9;   // plain window count, up to 31
  localparam int WNUM_W  = 50;  // weighted numerator
  localparam int WSUM_W  = 18;  // weight sum

  // item queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic             neg;
    logic [ACC_W-1:0] acc;
    logic [3:0]       frac;
  } job_t;

  // power of ten for the fraction digit count
  function automatic logic [DIV_DW-1:0] pow10(input logic [3:0] n);
    logic [DIV_DW-1:0] v;
    case (n)
      4'd0:  v = 50'd1;
      4'd1:  v = 50'd10;
      4'd2:  v = 50'd100;
      4'd3:  v = 50'd1000;
      4'd4:  v = 50'd10000;
      4'd5:  v = 50'd100000;
      4'd6:  v = 50'd1000000;
      4'd7:  v = 50'd10000000;
      4'd8:  v = 50'd100000000;
      4'd9:  v = 50'd1000000000;
      4'd10: v = 50'd10000000000;
      4'd11: v = 50'd100000000000;
      4'd12: v = 50'd1000000000000;
      4'd13: v = 50'd10000000000000;
      4'd14: v = 50'd100000000000000;
      default: v = 50'd1000000000000000;
    endcase
    return v;
  endfunction

  // apply sign to a quotient magnitude and saturate to signed 32 bits
  function automatic logic [31:0] sat_mag(input logic neg, input logic [DIV_QW-1:0] q,
                                          input logic ovf);
    logic [31:0] v;
    if (neg) begin
      if (ovf || q >= 33'h080000000) v = 32'h80000000;
      else v = 32'd0 - q[31:0];
    end else begin
      if (ovf || q > 33'h07FFFFFFF) v = 32'h7FFFFFFF;
      else v = q[31:0];
    end
    return v;
  endfunction

endpackage

>>> rtl/fama_front.sv
// front end: frame tracking and ascii decimal parsing of received bytes
module fama_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fama_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fama_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      rx_byte,
  input  logic                            queue_full,
  output logic                            push,
  output fama_pkg::job_t                  push_job
);

  localparam logic [2:0] PH_LEAD = 3'd0;
  localparam logic [2:0] PH_SIGN = 3'd1;
  localparam logic [2:0] PH_INT  = 3'd2;
  localparam logic [2:0] PH_FRAC = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [7:0] start_tag;
  logic [7:0] stop_tag;
  logic       in_frame;
  logic [2:0] phase;
  logic       neg;
  logic [fama_pkg::ACC_W-1:0] acc;
  logic [3:0] frac;

  logic [2:0] phase_next;
  logic       neg_next;
  logic [fama_pkg::ACC_W-1:0] acc_next;
  logic [3:0] frac_next;

  logic       accept;
  logic       is_digit;
  logic       is_space;
  logic [3:0] digit;
  logic [fama_pkg::ACC_W+3:0] times10;
  logic       fits;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && in_frame && (rx_byte == stop_tag);
  assign push_job = '{neg: neg, acc: acc, frac: frac};

  // character classes and the accumulator times ten plus digit
  assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign is_space = (rx_byte == 8'h20) || ((rx_byte >= 8'h09) && (rx_byte <= 8'h0D));
  assign digit    = rx_byte[3:0] - 4'd0;
  assign times10  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                  + {{fama_pkg::ACC_W{1'b0}}, digit};
  assign fits     = times10 <= {4'b0000, fama_pkg::ACC_MAX};

  // parser next state for one byte inside a frame
  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    acc_next   = acc;
    frac_next  = frac;
    case (phase)
      PH_LEAD, PH_SIGN, PH_INT: begin
        if (is_digit) begin
          phase_next = PH_INT;
          acc_next   = fits ? times10[fama_pkg::ACC_W-1:0] : fama_pkg::ACC_MAX;
        end else if (rx_byte == 8'h2E) begin
          phase_next = PH_FRAC;
        end else if (phase == PH_LEAD && is_space) begin
          phase_next = phase;
        end else if (phase == PH_LEAD && (rx_byte == 8'h2B || rx_byte == 8'h2D)) begin
          neg_next   = (rx_byte == 8'h2D);
          phase_next = PH_SIGN;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (!is_digit) begin
          phase_next = PH_DONE;
        end else if (frac < 4'd15 && fits) begin
          acc_next  = times10[fama_pkg::ACC_W-1:0];
          frac_next = frac + 4'd1;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  // tag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_tag <= 8'd65;
      stop_tag  <= 8'd66;
    end else if (cfg_write) begin
      if (cfg_index == fama_pkg::CFG_START_TAG) start_tag <= cfg_data[7:0];
      if (cfg_index == fama_pkg::CFG_STOP_TAG) stop_tag <= cfg_data[7:0];
    end
  end

  // frame and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      phase    <= PH_LEAD;
      neg      <= 1'b0;
      acc      <= '0;
      frac     <= '0;
    end else if (accept) begin
      if (!in_frame || rx_byte == stop_tag) begin
        if (!in_frame) in_frame <= (rx_byte == start_tag);
        else in_frame <= 1'b0;
        if (in_frame || rx_byte == start_tag) begin
          phase <= PH_LEAD;
          neg   <= 1'b0;
          acc   <= '0;
          frac  <= '0;
        end
      end else begin
        phase <= phase_next;
        neg   <= neg_next;
        acc   <= acc_next;
        frac  <= frac_next;
      end
    end
  end

endmodule

>>> rtl/fama_queue.sv
// short item queue between the front end and the back end
module fama_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fama_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output fama_pkg::job_t head
);

  localparam int AW = (fama_pkg::QUEUE_DEPTH > 1) ? $clog2(fama_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(fama_pkg::QUEUE_DEPTH + 1);

  fama_pkg::job_t entry [0:fama_pkg::QUEUE_DEPTH-1];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(fama_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entry[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) entry[wptr] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(fama_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop) rptr <= (rptr == AW'(fama_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/fama_div.sv
// restoring divider, one quotient bit per cycle, quotient kept with overflow flag
module fama_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fama_pkg::DIV_NW-1:0]   num,
  input  logic [fama_pkg::DIV_DW-1:0]   den,
  output logic                          busy,
  output logic                          done,
  output logic [fama_pkg::DIV_QW-1:0]   quo,
  output logic                          ovf
);

  logic [fama_pkg::DIV_NW-1:0] shreg;
  logic [fama_pkg::DIV_DW-1:0] dreg;
  logic [fama_pkg::DIV_DW-1:0] rem;
  logic [fama_pkg::DIV_CW-1:0] cnt;
  logic [fama_pkg::DIV_DW:0]   trial;
  logic [fama_pkg::DIV_DW:0]   diff;
  logic                        ge;

  // one trial subtraction
  assign trial = {rem, shreg[fama_pkg::DIV_NW-1]};
  assign ge    = trial >= {1'b0, dreg};
  assign diff  = trial - {1'b0, dreg};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= fama_pkg::DIV_CW'(fama_pkg::DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == fama_pkg::DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= num;
      dreg  <= den;
      rem   <= '0;
      quo   <= '0;
      ovf   <= 1'b0;
    end else if (busy) begin
      shreg <= {shreg[fama_pkg::DIV_NW-2:0], 1'b0};
      rem   <= ge ? diff[fama_pkg::DIV_DW-1:0] : trial[fama_pkg::DIV_DW-1:0];
      quo   <= {quo[fama_pkg::DIV_QW-2:0], ge};
      ovf   <= ovf | quo[fama_pkg::DIV_QW-1];
    end
  end

endmodule

>>> rtl/fama_back.sv
// back end: scaling, window update, plain and weighted averages, result register
module fama_back #(
  parameter int PLAIN_DEPTH  = fama_pkg::PLAIN_DEPTH_DEF,
  parameter int WEIGHT_DEPTH = fama_pkg::WEIGHT_DEPTH_DEF,
  parameter int FRAC_BITS    = fama_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fama_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fama_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            job_valid,
  input  fama_pkg::job_t                  job,
  output logic                            job_take,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              raw_value,
  output logic signed [31:0]              plain_average,
  output logic signed [31:0]              weighted_average,
  output logic                            weight_sum_zero
);

  localparam int AW    = (PLAIN_DEPTH > 1) ? $clog2(PLAIN_DEPTH) : 1;
  localparam int WAW   = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int SH_UP = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL_LO    = 4'd1;
  localparam logic [3:0] S_MUL_HI    = 4'd2;
  localparam logic [3:0] S_MUL_SUM   = 4'd3;
  localparam logic [3:0] S_SDIV_GO   = 4'd4;
  localparam logic [3:0] S_SDIV_WAIT = 4'd5;
  localparam logic [3:0] S_PUSH      = 4'd6;
  localparam logic [3:0] S_PSUM      = 4'd7;
  localparam logic [3:0] S_PDIV_GO   = 4'd8;
  localparam logic [3:0] S_PDIV_WAIT = 4'd9;
  localparam logic [3:0] S_WSUM      = 4'd10;
  localparam logic [3:0] S_WDIV_GO   = 4'd11;
  localparam logic [3:0] S_WDIV_WAIT = 4'd12;
  localparam logic [3:0] S_OUT       = 4'd13;

  // configuration
  logic [31:0] recip;
  logic [4:0]  plen;
  logic [2:0]  wlen;
  logic [63:0] wtab;

  // control
  logic [3:0] state;
  fama_pkg::job_t cur;

  // scaling datapath
  logic [63:0] prod_lo;
  logic [47:0] prod_hi;
  logic [fama_pkg::PROD_W-1:0] prod;
  logic [31:0] sample;

  // plain window memory
  logic [31:0] pmem [0:PLAIN_DEPTH-1];
  logic [PLAIN_DEPTH-1:0] pvalid;
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [31:0]   prd;
  logic          prd_ok;
  logic [fama_pkg::PCNT_W-1:0] ic;
  logic [fama_pkg::PCNT_W-1:0] pl_eff;
  logic          ppend;
  logic signed [fama_pkg::PSUM_W-1:0] psum;
  logic [31:0]   pavg;

  // weighted window
  logic [31:0] wwin [0:WEIGHT_DEPTH-1];
  logic [2:0]  wi;
  logic [2:0]  wl_eff;
  logic [2:0]  wsel;
  logic        wpend;
  logic signed [15:0] wcoef;
  logic signed [15:0] wcur;
  logic signed [47:0] wprod;
  logic signed [fama_pkg::WNUM_W-1:0] wnum;
  logic signed [fama_pkg::WSUM_W-1:0] wsum;
  logic [31:0] wavg;
  logic        wzero;

  // divider
  logic                        div_start;
  logic [fama_pkg::DIV_NW-1:0] div_num;
  logic [fama_pkg::DIV_DW-1:0] div_den;
  logic                        div_busy;
  logic                        div_done;
  logic [fama_pkg::DIV_QW-1:0] div_quo;
  logic                        div_ovf;

  logic [fama_pkg::PSUM_W-1:0] psum_mag;
  logic [fama_pkg::WNUM_W-1:0] wnum_mag;
  logic [fama_pkg::WSUM_W-1:0] wsum_mag;
  logic                        out_load;

  assign job_take = (state == S_IDLE) && job_valid;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // clamped window lengths
  always_comb begin
    if (plen == 5'd0) pl_eff = fama_pkg::PCNT_W'(1);
    else if (fama_pkg::PCNT_W'(plen) > fama_pkg::PCNT_W'(PLAIN_DEPTH))
      pl_eff = fama_pkg::PCNT_W'(PLAIN_DEPTH);
    else pl_eff = fama_pkg::PCNT_W'(plen);
    if (wlen == 3'd0) wl_eff = 3'd1;
    else if (wlen > 3'(WEIGHT_DEPTH)) wl_eff = 3'(WEIGHT_DEPTH);
    else wl_eff = wlen;
  end

  // weighted tap selection and its coefficient
  assign wsel  = 3'(WEIGHT_DEPTH) - wl_eff + wi;
  assign wcoef = wtab[{wi[1:0], 4'b0000} +: 16];

  // magnitudes for the shared divider
  assign psum_mag = psum[fama_pkg::PSUM_W-1] ? fama_pkg::PSUM_W'(-psum) : psum;
  assign wnum_mag = wnum[fama_pkg::WNUM_W-1] ? fama_pkg::WNUM_W'(-wnum) : wnum;
  assign wsum_mag = wsum[fama_pkg::WSUM_W-1] ? fama_pkg::WSUM_W'(-wsum) : wsum;

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = (fama_pkg::DIV_NW'(prod) << SH_UP) >> SH_DN;
    div_den   = fama_pkg::pow10(cur.frac);
    case (state)
      S_SDIV_GO: begin
        div_start = 1'b1;
      end
      S_PDIV_GO: begin
        div_start = 1'b1;
        div_num   = fama_pkg::DIV_NW'(psum_mag);
        div_den   = fama_pkg::DIV_DW'(pl_eff);
      end
      S_WDIV_GO: begin
        div_start = 1'b1;
        div_num   = fama_pkg::DIV_NW'(wnum_mag);
        div_den   = fama_pkg::DIV_DW'(wsum_mag);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  fama_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      recip <= 32'd65536;
      plen  <= 5'd16;
      wlen  <= 3'd4;
      wtab  <= '0;
    end else if (cfg_write) begin
      if (cfg_index == fama_pkg::CFG_SCALE_RECIP) recip <= cfg_data[31:0];
      if (cfg_index == fama_pkg::CFG_PLAIN_LEN) plen <= cfg_data[4:0];
      if (cfg_index == fama_pkg::CFG_WEIGHT_LEN) wlen <= cfg_data[2:0];
      if (cfg_index == fama_pkg::CFG_WEIGHT_TAB) wtab <= cfg_data;
    end
  end

  // plain window memory, registered read
  always_ff @(posedge clk) begin
    if (state == S_PUSH) pmem[wptr] <= sample;
    prd <= pmem[rptr];
  end

  // plain window valid bits, an invalid entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= '0;
    end else if (cfg_write && cfg_index == fama_pkg::CFG_PLAIN_LEN) begin
      pvalid <= '0;
    end else if (state == S_PUSH) begin
      pvalid[wptr] <= 1'b1;
    end
  end

  // weighted window shift register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WEIGHT_DEPTH; k++) wwin[k] <= '0;
    end else if (cfg_write && cfg_index == fama_pkg::CFG_WEIGHT_LEN) begin
      for (int k = 0; k < WEIGHT_DEPTH; k++) wwin[k] <= '0;
    end else if (state == S_PUSH) begin
      for (int k = 0; k < WEIGHT_DEPTH - 1; k++) wwin[k] <= wwin[k+1];
      wwin[WEIGHT_DEPTH-1] <= sample;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wptr  <= '0;
      rptr  <= '0;
      ppend <= 1'b0;
      wpend <= 1'b0;
      ic    <= '0;
      wi    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          prod_lo <= cur.acc[31:0] * recip;
          state   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_hi <= cur.acc[47:32] * recip;
          state   <= S_MUL_SUM;
        end
        S_MUL_SUM: begin
          prod  <= {16'd0, prod_lo} + {prod_hi, 32'd0};
          state <= S_SDIV_GO;
        end
        S_SDIV_GO: begin
          state <= S_SDIV_WAIT;
        end
        S_SDIV_WAIT: begin
          if (div_done) begin
            sample <= fama_pkg::sat_mag(cur.neg, div_quo, div_ovf);
            state  <= S_PUSH;
          end
        end
        S_PUSH: begin
          rptr  <= wptr;
          wptr  <= (wptr == AW'(PLAIN_DEPTH - 1)) ? '0 : wptr + 1'b1;
          ic    <= '0;
          ppend <= 1'b0;
          psum  <= '0;
          state <= S_PSUM;
        end
        S_PSUM: begin
          if (ic != pl_eff) begin
            prd_ok <= pvalid[rptr];
            rptr   <= (rptr == '0) ? AW'(PLAIN_DEPTH - 1) : rptr - 1'b1;
            ic     <= ic + 1'b1;
            ppend  <= 1'b1;
          end else begin
            ppend <= 1'b0;
          end
          if (ppend && prd_ok) begin
            psum <= psum + fama_pkg::PSUM_W'(signed'(prd));
          end
          if (ic == pl_eff && !ppend) state <= S_PDIV_GO;
        end
        S_PDIV_GO: begin
          state <= S_PDIV_WAIT;
        end
        S_PDIV_WAIT: begin
          if (div_done) begin
            pavg  <= fama_pkg::sat_mag(psum[fama_pkg::PSUM_W-1], div_quo, div_ovf);
            wi    <= '0;
            wpend <= 1'b0;
            wnum  <= '0;
            wsum  <= '0;
            state <= S_WSUM;
          end
        end
        S_WSUM: begin
          if (wi != wl_eff) begin
            wprod <= signed'(wwin[wsel[WAW-1:0]]) * wcoef;
            wcur  <= wcoef;
            wi    <= wi + 3'd1;
            wpend <= 1'b1;
          end else begin
            wpend <= 1'b0;
          end
          if (wpend) begin
            wnum <= wnum + fama_pkg::WNUM_W'(wprod);
            wsum <= wsum + fama_pkg::WSUM_W'(wcur);
          end
          if (wi == wl_eff && !wpend) begin
            if (wsum == '0) begin
              wavg  <= '0;
              wzero <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_WDIV_GO;
            end
          end
        end
        S_WDIV_GO: begin
          state <= S_WDIV_WAIT;
        end
        S_WDIV_WAIT: begin
          if (div_done) begin
            wavg  <= fama_pkg::sat_mag(wnum[fama_pkg::WNUM_W-1] ^ wsum[fama_pkg::WSUM_W-1],
                                       div_quo, div_ovf);
            wzero <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      raw_value        <= sample;
      plain_average    <= pavg;
      weighted_average <= wavg;
      weight_sum_zero  <= wzero;
    end
  end

  // divider is only started when free
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // divider finishes only where the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_SDIV_WAIT || state == S_PDIV_WAIT || state == S_WDIV_WAIT))
    else $error("divider result arrived with nobody waiting");

  // plain sum never reads past the window length
  a_psum_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PSUM) |-> (ic <= pl_eff))
    else $error("plain window read count beyond length");

endmodule

>>> rtl/framed_ascii_moving_average.sv
// top level of the framed ascii moving average block
//
// Input channel: one byte per item on rx_byte, taken when in_valid is high and
// in_stall is low. A start tag byte opens a frame, the decimal text inside is
// parsed as it arrives, and the stop tag byte closes it.
// Output channel: one item per closed frame with raw_value, plain_average and
// weighted_average (signed Q16.16 at the default fraction width) and
// weight_sum_zero, taken when out_valid is high and out_stall is low.
// Scaling and both averages share one divider, which makes one quotient bit per
// cycle. Frames are worked one at a time: the back end takes the next closed
// frame only after the result of the last one is loaded into the output register.
// Ordinary bytes are taken every cycle; up to two closed frames queue ahead
// of the arithmetic, after which in_stall is raised until the back end takes one.
// A stalled result is held in the output register while the next frame is
// computed. Reset restores the register defaults, closes any open frame and
// empties both windows. Configuration writes through cfg_write, cfg_index and
// cfg_data take effect at once; writing a window length empties that window.
module framed_ascii_moving_average #(
  parameter int PLAIN_DEPTH  = fama_pkg::PLAIN_DEPTH_DEF,
  parameter int WEIGHT_DEPTH = fama_pkg::WEIGHT_DEPTH_DEF,
  parameter int FRAC_BITS    = fama_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fama_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fama_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              raw_value,
  output logic signed [31:0]              plain_average,
  output logic signed [31:0]              weighted_average,
  output logic                            weight_sum_zero
);

  logic           push;
  fama_pkg::job_t push_job;
  logic           queue_full;
  logic           job_valid;
  logic           job_take;
  fama_pkg::job_t job;

  // byte parsing
  fama_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  // closed frames waiting for arithmetic
  fama_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (job_take),
    .head_valid (job_valid),
    .head       (job)
  );

  // scaling and averaging
  fama_back #(
    .PLAIN_DEPTH  (PLAIN_DEPTH),
    .WEIGHT_DEPTH (WEIGHT_DEPTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .job_valid        (job_valid),
    .job              (job),
    .job_take         (job_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .raw_value        (raw_value),
    .plain_average    (plain_average),
    .weighted_average (weighted_average),
    .weight_sum_zero  (weight_sum_zero)
  );

endmodule

>>> verif/fama_checker.sv
// checker for the framed ascii moving average: watches both channels, predicts and compares
module fama_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fama_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fama_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      rx_byte,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic signed [31:0]              raw_value,
  input  logic signed [31:0]              plain_average,
  input  logic signed [31:0]              weighted_average,
  input  logic                            weight_sum_zero,
  output int                              errors,
  output int                              pending,
  output int                              results_seen,
  output int                              zero_sum_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PD = fama_pkg::PLAIN_DEPTH_DEF;
  localparam int WD = fama_pkg::WEIGHT_DEPTH_DEF;
  localparam logic [63:0] ACC_TOP = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [31:0] raw;
    logic [31:0] pavg;
    logic [31:0] wavg;
    logic        wzero;
  } average_set_t;

  average_set_t expected_sets[$];

  // local copy of registers and state
  logic [7:0]  open_tag, close_tag;
  logic [31:0] recip;
  logic [4:0]  plen;
  logic [2:0]  wlen;
  logic [63:0] weights;
  logic        framed, minus;
  logic [2:0]  phase;
  logic [63:0] acc;
  logic [3:0]  fdigits;
  logic [31:0] plain_hist[PD];
  logic [31:0] weight_hist[WD];

  function automatic logic [63:0] ten_pow(input int n);
    logic [63:0] v;
    v = 1;
    for (int k = 0; k < n; k++) v = v * 10;
    return v;
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // scaled sample from the parsed digits
  function automatic logic [31:0] scaled_value();
    logic [79:0] prod;
    logic [79:0] q;
    prod = acc[47:0] * recip;
    q = prod / ten_pow(fdigits);
    if (minus) begin
      if (q >= 80'h80000000) return 32'h80000000;
      return 32'd0 - q[31:0];
    end
    if (q > 80'h7FFFFFFF) return 32'h7FFFFFFF;
    return q[31:0];
  endfunction

  // one text byte inside a frame
  task automatic parse_char(input logic [7:0] b);
    logic       is_digit;
    logic [63:0] d;
    is_digit = b >= "0" && b <= "9";
    d = b - "0";
    if (phase >= 4) return;
    if (phase == 3) begin
      if (!is_digit) begin
        phase = 4;
      end else if (fdigits < 15 && acc <= (ACC_TOP - d) / 10) begin
        acc = acc * 10 + d;
        fdigits++;
      end
      return;
    end
    if (is_digit) begin
      phase = 2;
      if (acc > (ACC_TOP - d) / 10) acc = ACC_TOP;
      else acc = acc * 10 + d;
    end else if (b == ".") begin
      phase = 3;
    end else if (phase == 0 && (b == " " || (b >= 9 && b <= 13))) begin
      // leading white space skipped
    end else if (phase == 0 && (b == "+" || b == "-")) begin
      minus = b == "-";
      phase = 1;
    end else begin
      phase = 4;
    end
  endtask

  task automatic clear_number();
    phase = 0;
    minus = 0;
    acc = 0;
    fdigits = 0;
  endtask

  // frame tracking; a stop byte inside a frame yields one expected average set
  task automatic take_byte(input logic [7:0] b);
    average_set_t e;
    longint sum, num, wsum, w;
    int pl, wl;
    if (!framed) begin
      if (b == open_tag) begin
        framed = 1;
        clear_number();
      end
      return;
    end
    if (b != close_tag) begin
      parse_char(b);
      return;
    end
    framed = 0;
    e.raw = scaled_value();
    clear_number();
    for (int k = 1; k < PD; k++) plain_hist[k-1] = plain_hist[k];
    plain_hist[PD-1] = e.raw;
    for (int k = 1; k < WD; k++) weight_hist[k-1] = weight_hist[k];
    weight_hist[WD-1] = e.raw;
    pl = plen < 1 ? 1 : (plen > PD ? PD : plen);
    wl = wlen < 1 ? 1 : (wlen > WD ? WD : wlen);
    sum = 0;
    for (int k = 0; k < pl; k++) sum += longint'(signed'(plain_hist[PD-1-k]));
    num = 0;
    wsum = 0;
    for (int k = 0; k < wl; k++) begin
      w = longint'(signed'(weights[16*k +: 16]));
      num += longint'(signed'(weight_hist[WD-wl+k])) * w;
      wsum += w;
    end
    e.pavg = clip32(sum / pl);
    e.wzero = wsum == 0;
    e.wavg = e.wzero ? 32'd0 : clip32(num / wsum);
    expected_sets.push_back(e);
  endtask

  // register writes
  task automatic write_reg(input logic [fama_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] v);
    case (idx)
      fama_pkg::CFG_START_TAG:   open_tag = v[7:0];
      fama_pkg::CFG_STOP_TAG:    close_tag = v[7:0];
      fama_pkg::CFG_SCALE_RECIP: recip = v[31:0];
      fama_pkg::CFG_PLAIN_LEN: begin
        plen = v[4:0];
        for (int k = 0; k < PD; k++) plain_hist[k] = 0;
      end
      fama_pkg::CFG_WEIGHT_LEN: begin
        wlen = v[2:0];
        for (int k = 0; k < WD; k++) weight_hist[k] = 0;
      end
      fama_pkg::CFG_WEIGHT_TAB:  weights = v;
      default: ;
    endcase
  endtask

  // result comparison
  task automatic compare_result();
    average_set_t e;
    results_seen++;
    if (weight_sum_zero) zero_sum_seen++;
    if (expected_sets.size() == 0) begin
      $display("%0t: unexpected result raw %h plain %h weighted %h zero %b", $time,
               raw_value, plain_average, weighted_average, weight_sum_zero);
      errors++;
      return;
    end
    e = expected_sets.pop_front();
    if (raw_value !== e.raw) begin
      $display("%0t: raw_value expected %h actual %h", $time, e.raw, raw_value);
      errors++;
    end
    if (plain_average !== e.pavg) begin
      $display("%0t: plain_average expected %h actual %h", $time, e.pavg, plain_average);
      errors++;
    end
    if (weighted_average !== e.wavg) begin
      $display("%0t: weighted_average expected %h actual %h", $time, e.wavg,
               weighted_average);
      errors++;
    end
    if (weight_sum_zero !== e.wzero) begin
      $display("%0t: weight_sum_zero expected %b actual %b", $time, e.wzero,
               weight_sum_zero);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    zero_sum_seen = 0;
  end

  assign pending = expected_sets.size();

  always @(posedge clk) begin
    if (rst) begin
      open_tag = 8'd65;
      close_tag = 8'd66;
      recip = 32'd65536;
      plen = 5'd16;
      wlen = 3'd4;
      weights = 0;
      framed = 0;
      clear_number();
      for (int k = 0; k < PD; k++) plain_hist[k] = 0;
      for (int k = 0; k < WD; k++) weight_hist[k] = 0;
      expected_sets.delete();
    end else begin
      if (out_valid && !out_stall) compare_result();
      if (cfg_write) write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) take_byte(rx_byte);
    end
  end

endmodule

>>> verif/tb_framed_ascii_moving_average.sv
// testbench top for the framed ascii moving average: stimulus, configuration and verdict
module tb_framed_ascii_moving_average;
  timeunit 1ns;
  timeprecision 1ps;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [fama_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fama_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [7:0]                      rx_byte;
  logic                            out_valid;
  logic                            out_stall;
  logic signed [31:0]              raw_value;
  logic signed [31:0]              plain_average;
  logic signed [31:0]              weighted_average;
  logic                            weight_sum_zero;

  int  errors, pending, results_seen, zero_sum_seen;
  int  bytes_sent;
  bit  quiet;
  logic [7:0] open_tag, close_tag;

  framed_ascii_moving_average uut (.*);

  fama_checker checker_i (.*);

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver stall, quiet stretches have none
  always @(negedge clk) begin
    out_stall <= !quiet && $urandom_range(99) < 15;
  end

  // run limit
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // one byte through the input handshake, with random gaps
  task automatic send_byte(input logic [7:0] b);
    if (!quiet) begin
      while ($urandom_range(99) < 15) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    rx_byte = b;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  // a well-formed frame with random content, sometimes broken
  task automatic send_frame();
    int n;
    send_byte(open_tag);
    repeat ($urandom_range(2)) send_byte($urandom_range(1) ? " " : 8'($urandom_range(9, 13)));
    case ($urandom_range(3))
      0: send_byte("-");
      1: send_byte("+");
      default: ;
    endcase
    n = $urandom_range(9) == 0 ? $urandom_range(12, 18) : $urandom_range(0, 5);
    repeat (n) send_byte(8'($urandom_range("0", "9")));
    if ($urandom_range(1)) begin
      send_byte(".");
      n = $urandom_range(9) == 0 ? $urandom_range(14, 18) : $urandom_range(0, 5);
      repeat (n) send_byte(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(5) == 0) repeat ($urandom_range(1, 3)) send_byte(8'($urandom()));
    if ($urandom_range(9) != 0) send_byte(close_tag);
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(9) < 8) send_frame();
      else send_byte(8'($urandom()));
    end
  endtask

  // let the block drain before touching registers
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (350) @(negedge clk);
  endtask

  task automatic write_reg(input logic [fama_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] v);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    if (idx == fama_pkg::CFG_START_TAG) open_tag = v[7:0];
    if (idx == fama_pkg::CFG_STOP_TAG) close_tag = v[7:0];
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    rx_byte = 8'd0;
    quiet = 1'b0;
    bytes_sent = 0;
    open_tag = "A";
    close_tag = "B";
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // defaults: stop outside a frame, signs, fraction, junk, empty, start inside
    send_text("BA-7.5BA\t+3x9BA.BAA2B");
    settle();

    // unit weights, full windows, long random stretch partly without gaps
    write_reg(fama_pkg::CFG_WEIGHT_TAB, 64'h0100_0100_0100_0100);
    quiet = 1'b1;
    random_traffic(60);
    quiet = 1'b0;
    random_traffic(90);
    settle();

    // shortest windows, extreme weights, equal tags, largest scale
    write_reg(fama_pkg::CFG_PLAIN_LEN, 64'd0);
    write_reg(fama_pkg::CFG_WEIGHT_LEN, 64'd0);
    write_reg(fama_pkg::CFG_WEIGHT_TAB, 64'h7FFF_8000_8000_8000);
    write_reg(fama_pkg::CFG_START_TAG, 64'd35);
    write_reg(fama_pkg::CFG_STOP_TAG, 64'd35);
    write_reg(fama_pkg::CFG_SCALE_RECIP, 64'hFFFF_FFFF);
    random_traffic(90);
    settle();

    // oversized lengths clamp, zero weight sum, scale zero, tags at the byte extremes
    write_reg(fama_pkg::CFG_PLAIN_LEN, 64'd31);
    write_reg(fama_pkg::CFG_WEIGHT_LEN, 64'd7);
    write_reg(fama_pkg::CFG_WEIGHT_TAB, 64'hFF00_0100_FE00_0200);
    write_reg(fama_pkg::CFG_START_TAG, 64'd0);
    write_reg(fama_pkg::CFG_STOP_TAG, 64'hFF);
    write_reg(fama_pkg::CFG_SCALE_RECIP, 64'd0);
    write_reg(3'd6, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(3'd7, 64'd0);
    random_traffic(60);
    settle();

    // random settings, a digit and the decimal point as tags
    write_reg(fama_pkg::CFG_SCALE_RECIP, 64'($urandom_range(1, 200000)));
    write_reg(fama_pkg::CFG_PLAIN_LEN, 64'($urandom_range(1, 16)));
    write_reg(fama_pkg::CFG_WEIGHT_LEN, 64'($urandom_range(1, 4)));
    write_reg(fama_pkg::CFG_WEIGHT_TAB, {32'($urandom()), 32'($urandom())});
    write_reg(fama_pkg::CFG_START_TAG, 64'("1"));
    write_reg(fama_pkg::CFG_STOP_TAG, 64'("."));
    random_traffic(80);
    settle();

    // back to plain tags with random lengths, table and scale
    write_reg(fama_pkg::CFG_START_TAG, 64'("<"));
    write_reg(fama_pkg::CFG_STOP_TAG, 64'(">"));
    write_reg(fama_pkg::CFG_SCALE_RECIP, 64'($urandom()));
    write_reg(fama_pkg::CFG_PLAIN_LEN, 64'($urandom_range(2, 15)));
    write_reg(fama_pkg::CFG_WEIGHT_LEN, 64'($urandom_range(2, 3)));
    write_reg(fama_pkg::CFG_WEIGHT_TAB, {32'($urandom()), 32'($urandom())});
    random_traffic(150);
    settle();

    $display("sent %0d bytes over six register settings", bytes_sent);
    $display("checked %0d results, %0d with zero weight sum", results_seen, zero_sum_seen);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/fama_pkg.sv
rtl/fama_front.sv
rtl/fama_queue.sv
rtl/fama_div.sv
rtl/fama_back.sv
rtl/framed_ascii_moving_average.sv
verif/fama_checker.sv
verif/tb_framed_ascii_moving_average.sv
